/* sv/hcm_pkg.sv */
// types, constants and per-stage level logic for the hilbert curve map unit
`default_nettype none

package hcm_pkg;

    localparam int unsigned MAX_ORDER   = 32;
    localparam int unsigned LVL_PER_STG = 4;
    localparam int unsigned N_GRP       = MAX_ORDER / LVL_PER_STG;
    localparam int unsigned NSTG        = N_GRP + 2;
    localparam int unsigned CW          = 32;
    localparam int unsigned DW          = 64;
    localparam int unsigned OW          = 6;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [OW-1:0] ORDER_RESET = OW'(MAX_ORDER);

    typedef struct packed {
        logic          op;
        logic          swp;
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic [DW-1:0] d;
    } t_stg;

    // one group of bit levels, coarse to fine for encode, fine to coarse for decode
    function automatic t_stg grp_step(input int unsigned g, input t_stg s);
        t_stg          r;
        logic          qx;
        logic          qy;
        logic [CW-1:0] low;
        logic [CW-1:0] ta;
        logic [CW-1:0] tb;
        int unsigned   lv;
        r = s;
        for (int unsigned j = 0; j < LVL_PER_STG; j++) begin
            if (r.op == OP_ENCODE) begin
                lv = MAX_ORDER - 1 - g * LVL_PER_STG - j;
                qx = r.a[lv];
                qy = r.b[lv];
                r.d[2*lv+1] = qx;
                r.d[2*lv]   = qx ^ qy;
            end else begin
                lv = g * LVL_PER_STG + j;
                qx = r.d[2*lv+1];
                qy = r.d[2*lv] ^ qx;
            end
            low = (CW'(1) << lv) - CW'(1);
            if (!qy) begin
                ta = r.a & low;
                tb = r.b & low;
                if (qx) begin
                    ta = ta ^ low;
                    tb = tb ^ low;
                end
                r.a = tb;
                r.b = ta;
            end
            if (r.op == OP_DECODE) begin
                r.a[lv] = qx;
                r.b[lv] = qy;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/hilbert_curve_map_unit.sv */
// hilbert curve map unit: pipelined coordinate to distance and distance to coordinate
//
// input stream (i_s_*): one request per accepted beat; tuser selects encode (0)
// or decode (1); tdata carries coord_x, coord_y and curve_distance
// output stream (o_m_*): one result per request, in request order; tdata carries
// result_distance, result_x and result_y
// config channel (i_cfg_*): writes curve_order; the user must write it only while idle,
// as the block itself leaves this unchecked
// stages: one entry stage, eight level stages of four bit levels each, one output stage
// throughput: one request per cycle while the output is not stalled; each stage
// holds one request and has its own valid bit, so bubbles fill while the output is stalled
// a stalled receiver holds the output stage; upstream stages keep loading until
// the pipe is full, then o_s_tready drops; nothing is lost or repeated
// reset empties the pipe and sets curve_order to 32
`default_nettype none

module hilbert_curve_map_unit
    import hcm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [5:0]   i_cfg_data,     // curve_order
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,      // coord_x, coord_y, curve_distance
    input  wire logic [0:0]   i_s_tuser,      // operation
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata       // result_distance, result_x, result_y
);

    logic [OW-1:0] r_order;
    logic [OW-1:0] ord;
    logic [CW-1:0] cmask;
    logic [DW-1:0] dmask;
    logic [CW-1:0] xm;
    logic [CW-1:0] ym;
    logic          ld   [NSTG];
    logic          r_vld[NSTG];
    t_stg          r_stg[NSTG];
    t_stg          n_stg[NSTG];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_valid) begin
            r_order <= i_cfg_data;
        end
    end

    // saturated order and masks for the high input bits
    always_comb begin
        ord   = (r_order > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : r_order;
        cmask = {CW{1'b1}} >> (OW'(CW) - ord);
        dmask = {DW{1'b1}} >> (7'(DW) - {ord, 1'b0});
        xm    = i_s_tdata[31:0] & cmask;
        ym    = i_s_tdata[63:32] & cmask;
    end

    // stage ready chain
    always_comb begin
        ld[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_s_tready = ld[0];

    always_comb begin
        // entry stage: mask, then pre-swap so a fixed full-order pass gives the same result
        n_stg[0].op  = i_s_tuser[0];
        n_stg[0].swp = ord[0];
        if (i_s_tuser[0] == OP_ENCODE) begin
            n_stg[0].a = ord[0] ? ym : xm;
            n_stg[0].b = ord[0] ? xm : ym;
            n_stg[0].d = '0;
        end else begin
            n_stg[0].a = '0;
            n_stg[0].b = '0;
            n_stg[0].d = i_s_tdata[127:64] & dmask;
        end

        for (int unsigned k = 1; k <= N_GRP; k++) begin
            n_stg[k] = grp_step(k - 1, r_stg[k-1]);
        end

        // output formatting, post-swap for decode
        n_stg[NSTG-1] = r_stg[NSTG-2];
        if (r_stg[NSTG-2].op == OP_ENCODE) begin
            n_stg[NSTG-1].a = '0;
            n_stg[NSTG-1].b = '0;
        end else begin
            n_stg[NSTG-1].a = r_stg[NSTG-2].swp ? r_stg[NSTG-2].b : r_stg[NSTG-2].a;
            n_stg[NSTG-1].b = r_stg[NSTG-2].swp ? r_stg[NSTG-2].a : r_stg[NSTG-2].b;
            n_stg[NSTG-1].d = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= ld[0] ? i_s_tvalid : r_vld[0];
            for (int k = 1; k < NSTG; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (ld[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {r_stg[NSTG-1].b, r_stg[NSTG-1].a, r_stg[NSTG-1].d};

`ifndef SYNTH
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_vld[0])
        else $error("accepted request did not reach entry stage");

    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !ld[4] |=> r_vld[4] && $stable(r_stg[4]))
        else $error("stalled middle stage changed");

    a_enc_zero_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_stg[NSTG-1].op == OP_ENCODE) |-> (o_m_tdata[127:64] == '0))
        else $error("encode result has nonzero coordinates");

    a_dec_zero_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_stg[NSTG-1].op == OP_DECODE) |-> (o_m_tdata[63:0] == '0))
        else $error("decode result has nonzero distance");
`endif

endmodule

`default_nettype wire
